### sv/ddp_pkg.sv
// Shared types, codes and constants for the DDP to RGB565 pixel writer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package ddp_pkg;

  // Frame size limit in pixels, default for the top-level parameter.
  localparam int MAX_PIXELS_DEF = 65536;

  // DDP header size in bytes.
  localparam int unsigned HDR_BYTES = 10;

  localparam logic [7:0] FLAG_VERSION = 8'h40;
  localparam logic [7:0] FLAG_PUSH    = 8'h01;
  localparam logic [7:0] RED_MASK     = 8'hF8;
  localparam logic [7:0] GREEN_MASK   = 8'hFC;

  // Exact division by three through a reciprocal multiply.
  localparam logic [31:0] DIV3_MUL32   = 32'hAAAA_AAAB;
  localparam int          DIV3_SHIFT32 = 33;
  localparam logic [15:0] DIV3_MUL16   = 16'hAAAB;
  localparam int          DIV3_SHIFT16 = 17;

  localparam int FRAME_DIM_W = 11;
  localparam int PROD_W      = 2 * FRAME_DIM_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  // Result queue depth, a power of two.
  localparam int RES_DEPTH = 4;

  typedef enum logic [1:0] {
    REQ_HEADER = 2'd0,
    REQ_BYTE   = 2'd1,
    REQ_TAKEN  = 2'd2
  } req_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STREAM = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2,
    CFG_SWAP   = 2'd3
  } cfg_idx_t;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  hdr_flags;
    logic [7:0]  hdr_stream;
    logic [31:0] hdr_offset;
    logic [15:0] hdr_length;
    logic [15:0] datagram_length;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] pixel_address;
    logic [15:0] pixel_color;
    logic        overrun;
    logic        last;
  } res_t;

  // Decoded item handed from the header checker to the state stage.
  typedef struct packed {
    logic [1:0]  req_type;
    logic        hdr_good;
    logic        hdr_zero_push;
    logic        push;
    logic [15:0] start_pixel;
    logic [15:0] pixel_count;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
  } dec_t;

endpackage

`default_nettype wire

### sv/ddp_req_if.sv
// Request channel: valid/ready handshake carrying one header, byte or take item.
// Depends on ddp_pkg for the payload type.
`default_nettype none

interface ddp_req_if;
  logic          valid;
  logic          ready;
  ddp_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/ddp_res_if.sv
// Result channel: valid/ready handshake carrying one pixel write or frame-ready.
// Depends on ddp_pkg for the payload type.
`default_nettype none

interface ddp_res_if;
  logic          valid;
  logic          ready;
  ddp_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/ddp_hdr_check.sv
// Two-stage header checker: divides offset and length by three, validates the
// packet against the frame setup and forwards every item in order. Uses ddp_pkg.
`default_nettype none

module ddp_hdr_check #(
  parameter int MAX_PIXELS = ddp_pkg::MAX_PIXELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  logic                               in_valid,
  input  ddp_pkg::req_t                      in_item,
  input  logic [7:0]                         stream_select,
  input  logic [ddp_pkg::FRAME_DIM_W-1:0]    frame_width,
  input  logic [ddp_pkg::FRAME_DIM_W-1:0]    frame_height,
  output logic                               out_valid,
  output ddp_pkg::dec_t                      out_dec
);

  localparam int PIX_W = $clog2(MAX_PIXELS + 1);

  // Frame size follows the configuration through the frame_prod and max_px registers.
  logic [ddp_pkg::PROD_W-1:0] frame_prod;
  logic [PIX_W-1:0]           max_px;

  always_ff @(posedge clk) begin
    frame_prod <= ddp_pkg::PROD_W'(frame_width) * ddp_pkg::PROD_W'(frame_height);
    if (32'(frame_prod) > 32'(MAX_PIXELS)) begin
      max_px <= PIX_W'(MAX_PIXELS);
    end else begin
      max_px <= PIX_W'(frame_prod);
    end
  end

  // First stage: reciprocal multiplies and the checks that need no quotient.
  logic [63:0] off_prod;
  logic [31:0] len_prod;
  logic        common_ok_c;
  logic        len_fits_c;

  always_comb begin
    off_prod = 64'(in_item.hdr_offset) * 64'(ddp_pkg::DIV3_MUL32);
    len_prod = 32'(in_item.hdr_length) * 32'(ddp_pkg::DIV3_MUL16);
    common_ok_c = (in_item.datagram_length >= 16'(ddp_pkg::HDR_BYTES))
                  && ((in_item.hdr_flags & ddp_pkg::FLAG_VERSION) != 8'h00)
                  && (in_item.hdr_stream == stream_select)
                  && (frame_width != '0) && (frame_height != '0);
    len_fits_c = (17'(ddp_pkg::HDR_BYTES) + 17'(in_item.hdr_length))
                 <= 17'(in_item.datagram_length);
  end

  logic        s2_valid;
  logic [1:0]  s2_req_type;
  logic [7:0]  s2_data_byte;
  logic        s2_push;
  logic        s2_common_ok;
  logic        s2_len_zero;
  logic        s2_len_fits;
  logic [31:0] s2_off;
  logic [15:0] s2_len;
  logic [30:0] s2_q_off;
  logic [14:0] s2_q_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (advance) begin
      s2_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_req_type  <= in_item.req_type;
      s2_data_byte <= in_item.data_byte;
      s2_push      <= (in_item.hdr_flags & ddp_pkg::FLAG_PUSH) != 8'h00;
      s2_common_ok <= common_ok_c;
      s2_len_zero  <= in_item.hdr_length == 16'd0;
      s2_len_fits  <= len_fits_c;
      s2_off       <= in_item.hdr_offset;
      s2_len       <= in_item.hdr_length;
      s2_q_off     <= off_prod[63:ddp_pkg::DIV3_SHIFT32];
      s2_q_len     <= len_prod[31:ddp_pkg::DIV3_SHIFT16];
    end
  end

  // Second stage: divisibility, start pixel inside the frame, clipped count.
  logic [32:0]   off_back;
  logic [16:0]   len_back;
  logic          in_frame;
  logic [31:0]   room;
  logic [15:0]   count;
  ddp_pkg::dec_t dec_c;

  always_comb begin
    off_back = 33'({s2_q_off, 1'b0}) + 33'(s2_q_off);
    len_back = 17'({s2_q_len, 1'b0}) + 17'(s2_q_len);
    in_frame = 32'(s2_q_off) < 32'(max_px);
    room     = 32'(max_px) - 32'(s2_q_off);
    if (32'(s2_q_len) < room) begin
      count = 16'(s2_q_len);
    end else begin
      count = room[15:0];
    end
    dec_c.req_type      = s2_req_type;
    dec_c.hdr_good      = s2_common_ok && !s2_len_zero && s2_len_fits
                          && (off_back == 33'(s2_off)) && (len_back == 17'(s2_len))
                          && in_frame;
    dec_c.hdr_zero_push = s2_common_ok && s2_len_zero && s2_push;
    dec_c.push          = s2_push;
    dec_c.start_pixel   = s2_q_off[15:0];
    dec_c.pixel_count   = count;
    dec_c.byte_count    = s2_len;
    dec_c.data_byte     = s2_data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dec <= dec_c;
    end
  end

endmodule

`default_nettype wire

### sv/ddp_res_fifo.sv
// Small result queue: takes up to two results a cycle, hands out one per transfer.
// Depends on ddp_pkg and drives the result channel interface.
`default_nettype none

module ddp_res_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_cnt,
  input  ddp_pkg::res_t    push0,
  input  ddp_pkg::res_t    push1,
  output logic             has_room,
  ddp_res_if.source        res
);

  localparam int DEPTH = ddp_pkg::RES_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ddp_pkg::res_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_p1;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign wr_ptr_p1   = wr_ptr + PTR_W'(1);
  assign pop         = res.valid && res.ready;
  assign res.valid   = count != '0;
  assign res.payload = mem[rd_ptr];
  // Room for the two results one item may bring.
  assign has_room    = count <= CNT_W'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

### sv/ddp_packet_to_rgb565_writer.sv
// Top level of the DDP receiver that turns RGB888 payload into RGB565 pixel writes.
// Depends on ddp_pkg, ddp_req_if, ddp_res_if, ddp_hdr_check and ddp_res_fifo.
//
//   Channel  Direction  Handshake             Carries
//   req      in         valid/ready           header, payload byte or frame taken
//   res      out        valid/ready           pixel write or frame-ready result
//   cfg      in         cfg_we, no wait       stream, width, height, byte swap
//
// One item is accepted per cycle while the result queue has room. Each item
// passes an input register, two header-check stages and the state stage, which
// writes its results into the result queue. The 32-bit reciprocal multiply for
// offset / 3 sets the length of the first check stage. The whole pipeline
// stalls while the result queue holds more than two results, so an item that
// brings two results never overflows it. Synchronous reset clears all control
// state and restores the configuration defaults; no clearing pass is needed.
`default_nettype none

module ddp_packet_to_rgb565_writer #(
  parameter int MAX_PIXELS = ddp_pkg::MAX_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  ddp_req_if.sink                         req,
  ddp_res_if.source                       res,
  input  logic                            cfg_we,
  input  logic [ddp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ddp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [7:0]                      stream_select;
  logic [ddp_pkg::FRAME_DIM_W-1:0] frame_width;
  logic [ddp_pkg::FRAME_DIM_W-1:0] frame_height;
  logic                            swap_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_select <= 8'd1;
      frame_width   <= '0;
      frame_height  <= '0;
      swap_bytes    <= 1'b0;
    end else if (cfg_we) begin
      case (ddp_pkg::cfg_idx_t'(cfg_index))
        ddp_pkg::CFG_STREAM: stream_select <= cfg_data[7:0];
        ddp_pkg::CFG_WIDTH:  frame_width   <= cfg_data[ddp_pkg::FRAME_DIM_W-1:0];
        ddp_pkg::CFG_HEIGHT: frame_height  <= cfg_data[ddp_pkg::FRAME_DIM_W-1:0];
        ddp_pkg::CFG_SWAP:   swap_bytes    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // All pipeline stages move together; they hold while the queue lacks room.
  logic advance;
  assign req.ready = advance;

  // Input register.
  logic          s1_valid;
  ddp_pkg::req_t s1_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item <= req.payload;
    end
  end

  logic          dec_valid;
  ddp_pkg::dec_t dec;

  ddp_hdr_check #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_hdr_check (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (s1_valid),
    .in_item       (s1_item),
    .stream_select (stream_select),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .out_valid     (dec_valid),
    .out_dec       (dec)
  );

  // Packet state.
  logic        accepting, accepting_next;
  logic [15:0] next_pixel, next_pixel_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] pixels_left, pixels_left_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic [7:0]  held_red, held_red_next;
  logic [7:0]  held_green, held_green_next;
  logic        push_pending, push_pending_next;
  logic        frame_waiting, frame_waiting_next;

  logic          step;
  logic [1:0]    n_res;
  ddp_pkg::res_t res0;
  ddp_pkg::res_t res1;
  ddp_pkg::res_t ready_res;
  logic [15:0]   color;
  logic [15:0]   bytes_dec;

  assign step = advance && dec_valid;

  always_comb begin
    accepting_next     = accepting;
    next_pixel_next    = next_pixel;
    bytes_left_next    = bytes_left;
    pixels_left_next   = pixels_left;
    byte_phase_next    = byte_phase;
    held_red_next      = held_red;
    held_green_next    = held_green;
    push_pending_next  = push_pending;
    frame_waiting_next = frame_waiting;
    n_res              = 2'd0;
    res0               = '0;
    res1               = '0;
    bytes_dec          = bytes_left;

    // A frame-ready result reports whether the previous frame is still untaken.
    ready_res         = '0;
    ready_res.kind    = ddp_pkg::KIND_FRAME;
    ready_res.overrun = frame_waiting;

    // RGB888 to RGB565: the third byte of a triplet is blue.
    color = {held_red & ddp_pkg::RED_MASK, 8'h00}
            | (16'(held_green & ddp_pkg::GREEN_MASK) << 3)
            | 16'(dec.data_byte >> 3);
    if (swap_bytes) begin
      color = {color[7:0], color[15:8]};
    end

    case (ddp_pkg::req_code_t'(dec.req_type))
      ddp_pkg::REQ_HEADER: begin
        // Any header ends the packet in progress, dropped or not.
        accepting_next    = 1'b0;
        push_pending_next = 1'b0;
        byte_phase_next   = 2'd0;
        if (dec.hdr_good) begin
          accepting_next    = 1'b1;
          next_pixel_next   = dec.start_pixel;
          bytes_left_next   = dec.byte_count;
          pixels_left_next  = dec.pixel_count;
          push_pending_next = dec.push;
        end else if (dec.hdr_zero_push) begin
          res0               = ready_res;
          n_res              = 2'd1;
          frame_waiting_next = 1'b1;
        end
      end
      ddp_pkg::REQ_BYTE: begin
        if (accepting) begin
          if (byte_phase == 2'd0) begin
            held_red_next   = dec.data_byte;
            byte_phase_next = 2'd1;
          end else if (byte_phase == 2'd1) begin
            held_green_next = dec.data_byte;
            byte_phase_next = 2'd2;
          end else begin
            byte_phase_next = 2'd0;
            // Triplets past the frame end are consumed without a write.
            if (pixels_left != 16'd0) begin
              res0.kind          = ddp_pkg::KIND_PIXEL;
              res0.pixel_address = next_pixel;
              res0.pixel_color   = color;
              n_res              = 2'd1;
              next_pixel_next    = next_pixel + 16'd1;
              pixels_left_next   = pixels_left - 16'd1;
            end
          end
          if (bytes_left != 16'd0) begin
            bytes_dec = bytes_left - 16'd1;
          end
          bytes_left_next = bytes_dec;
          if (bytes_dec == 16'd0) begin
            accepting_next  = 1'b0;
            byte_phase_next = 2'd0;
            if (push_pending) begin
              push_pending_next  = 1'b0;
              frame_waiting_next = 1'b1;
              if (n_res == 2'd0) begin
                res0 = ready_res;
              end else begin
                res1 = ready_res;
              end
              n_res = n_res + 2'd1;
            end
          end
        end
      end
      ddp_pkg::REQ_TAKEN: begin
        frame_waiting_next = 1'b0;
      end
      default: ;
    endcase

    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end else if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accepting     <= 1'b0;
      next_pixel    <= '0;
      bytes_left    <= '0;
      pixels_left   <= '0;
      byte_phase    <= '0;
      push_pending  <= 1'b0;
      frame_waiting <= 1'b0;
    end else if (step) begin
      accepting     <= accepting_next;
      next_pixel    <= next_pixel_next;
      bytes_left    <= bytes_left_next;
      pixels_left   <= pixels_left_next;
      byte_phase    <= byte_phase_next;
      push_pending  <= push_pending_next;
      frame_waiting <= frame_waiting_next;
    end
  end

  // Held color bytes are only read after they were written.
  always_ff @(posedge clk) begin
    if (step) begin
      held_red   <= held_red_next;
      held_green <= held_green_next;
    end
  end

  ddp_res_fifo u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (step ? n_res : 2'd0),
    .push0    (res0),
    .push1    (res1),
    .has_room (advance),
    .res      (res)
  );

endmodule

`default_nettype wire
